// ===== rtl/wsdf_pkg.sv =====
// ----------------------------------------------------------------------------
// wsdf_pkg
// Shared types and codes for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsdf_pkg;

  // parser phases
  localparam logic [2:0] PH_HDR0  = 3'd0;
  localparam logic [2:0] PH_HDR1  = 3'd1;
  localparam logic [2:0] PH_EXT   = 3'd2;
  localparam logic [2:0] PH_MASK  = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_ERROR = 3'd5;

  // result kinds (carried on tuser)
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error codes, in check order
  localparam logic [2:0] ERR_RSV       = 3'd0;
  localparam logic [2:0] ERR_NOT_FINAL = 3'd1;
  localparam logic [2:0] ERR_UNMASKED  = 3'd2;
  localparam logic [2:0] ERR_BAD_OP    = 3'd3;
  localparam logic [2:0] ERR_CTRL_LONG = 3'd4;
  localparam logic [2:0] ERR_TOO_LONG  = 3'd5;

  // register map (byte address bit 2 selects the register)
  localparam logic REG_MAX_PAYLOAD = 1'b0;
  localparam logic REG_MAX_CONTROL = 1'b1;

  localparam logic [31:0] MAX_PAYLOAD_RST = 32'h0010_0000;
  localparam logic [6:0]  MAX_CONTROL_RST = 7'd125;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  typedef struct packed {
    logic [31:0] max_payload;
    logic [6:0]  max_control;
  } wsdf_limits_t;

endpackage

// ===== rtl/wsdf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// wsdf_cfg_regs
// APB register file holding the payload length limits.
// ----------------------------------------------------------------------------
module wsdf_cfg_regs (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output wsdf_pkg::wsdf_limits_t limits
);

  logic [31:0] max_payload_r;
  logic [6:0]  max_control_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= wsdf_pkg::MAX_PAYLOAD_RST;
      max_control_r <= wsdf_pkg::MAX_CONTROL_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        wsdf_pkg::REG_MAX_PAYLOAD: max_payload_r <= pwdata;
        wsdf_pkg::REG_MAX_CONTROL: max_control_r <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      wsdf_pkg::REG_MAX_PAYLOAD: prdata = max_payload_r;
      wsdf_pkg::REG_MAX_CONTROL: prdata = {25'd0, max_control_r};
      default:                   prdata = 32'd0;
    endcase
  end

  assign limits.max_payload = max_payload_r;
  assign limits.max_control = max_control_r;

endmodule

// ===== rtl/websocket_frame_deframer_core.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer_core
// Client-to-server WebSocket deframer: header parse, limit checks, unmasking.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one received stream byte per item (in_tdata).
//   out_* : zero or one result per input byte. tuser = kind (payload byte,
//           empty frame, error); tlast marks the final payload byte of a frame
//           or an empty frame; tdata carries the byte, opcode and error code.
//   cfg_* : APB port, 0x0 max_payload_bytes, 0x4 max_control_bytes. Write
//           only while the stream is idle.
// Latency: a result appears on out_tvalid the cycle after the byte that
//   causes it is accepted. Throughput is one byte per cycle while results are
//   taken (out_tready high): the parser phase update and the length compare
//   sit between the accept edge and the single output register.
// Stall: in_tready = !out_tvalid | out_tready, so a held result stalls input
//   only until it is taken; bytes that yield no result still need a free slot.
// Reset: synchronous rst_n returns to "first header byte expected", clears
//   the output slot and restores the default limits. An error is reported
//   once and then all further bytes are swallowed until reset.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] data_byte, [11:8] opcode,
                                  // [14:12] error_code, [15] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,  // last
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  wsdf_pkg::wsdf_limits_t limits;

  wsdf_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .limits  (limits)
  );

  // parser state
  logic [2:0]  phase_r,   phase_nxt;
  logic [7:0]  hdr0_r,    hdr0_nxt;
  logic [63:0] dlen_r,    dlen_nxt;
  logic [3:0]  ext_r,     ext_nxt;
  logic [31:0] key_r,     key_nxt;
  logic [1:0]  keycnt_r,  keycnt_nxt;
  logic [31:0] left_r,    left_nxt;
  logic [1:0]  kidx_r,    kidx_nxt;

  // output slot
  logic        ovld_r;
  logic [1:0]  okind_r,   okind_nxt;
  logic [7:0]  odata_r,   odata_nxt;
  logic [3:0]  oop_r;
  logic        olast_r,   olast_nxt;
  logic [2:0]  ocode_r,   ocode_nxt;
  logic        res_nxt;

  logic        in_acc;
  logic [7:0]  b;
  logic [3:0]  op;
  logic        len_chk;
  logic [63:0] len_full;
  logic [7:0]  kb;

  assign in_tready = ~ovld_r | out_tready;
  assign in_acc    = in_tvalid & in_tready;
  assign b         = in_tdata;
  assign op        = hdr0_r[3:0];

  // mask key byte 0 is the first received, i.e. the top byte of key_r
  always_comb begin
    case (kidx_r)
      2'd0:    kb = key_r[31:24];
      2'd1:    kb = key_r[23:16];
      2'd2:    kb = key_r[15:8];
      default: kb = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    hdr0_nxt   = hdr0_r;
    dlen_nxt   = dlen_r;
    ext_nxt    = ext_r;
    key_nxt    = key_r;
    keycnt_nxt = keycnt_r;
    left_nxt   = left_r;
    kidx_nxt   = kidx_r;
    res_nxt    = 1'b0;
    okind_nxt  = wsdf_pkg::KIND_DATA;
    odata_nxt  = 8'd0;
    olast_nxt  = 1'b0;
    ocode_nxt  = wsdf_pkg::ERR_RSV;
    len_chk    = 1'b0;
    len_full   = {57'd0, b[6:0]};

    unique case (phase_r)
      wsdf_pkg::PH_HDR0: begin
        hdr0_nxt  = b;
        phase_nxt = wsdf_pkg::PH_HDR1;
      end
      wsdf_pkg::PH_HDR1: begin
        dlen_nxt = 64'd0;
        if (hdr0_r[6:4] != 3'd0) begin
          res_nxt   = 1'b1;
          ocode_nxt = wsdf_pkg::ERR_RSV;
        end else if (!hdr0_r[7]) begin
          res_nxt   = 1'b1;
          ocode_nxt = wsdf_pkg::ERR_NOT_FINAL;
        end else if (!b[7]) begin
          res_nxt   = 1'b1;
          ocode_nxt = wsdf_pkg::ERR_UNMASKED;
        end else if (op > 4'hA || (op > 4'h2 && op < 4'h8)) begin
          res_nxt   = 1'b1;
          ocode_nxt = wsdf_pkg::ERR_BAD_OP;
        end else if (b[6:0] == wsdf_pkg::LEN7_EXT16) begin
          ext_nxt   = 4'd2;
          phase_nxt = wsdf_pkg::PH_EXT;
        end else if (b[6:0] == wsdf_pkg::LEN7_EXT64) begin
          ext_nxt   = 4'd8;
          phase_nxt = wsdf_pkg::PH_EXT;
        end else begin
          len_chk = 1'b1;
        end
      end
      wsdf_pkg::PH_EXT: begin
        len_full = {dlen_r[55:0], b};
        dlen_nxt = len_full;
        ext_nxt  = ext_r - 4'd1;
        len_chk  = (ext_r == 4'd1);
      end
      wsdf_pkg::PH_MASK: begin
        key_nxt    = {key_r[23:0], b};
        keycnt_nxt = keycnt_r + 2'd1;
        if (keycnt_r == 2'd3) begin
          kidx_nxt = 2'd0;
          if (left_r == 32'd0) begin
            res_nxt   = 1'b1;
            okind_nxt = wsdf_pkg::KIND_EMPTY;
            olast_nxt = 1'b1;
            phase_nxt = wsdf_pkg::PH_HDR0;
          end else begin
            phase_nxt = wsdf_pkg::PH_DATA;
          end
        end
      end
      wsdf_pkg::PH_DATA: begin
        res_nxt   = 1'b1;
        odata_nxt = b ^ kb;
        kidx_nxt  = kidx_r + 2'd1;
        left_nxt  = left_r - 32'd1;
        olast_nxt = (left_r == 32'd1);
        if (left_r == 32'd1) phase_nxt = wsdf_pkg::PH_HDR0;
      end
      default: ; // error phase: swallow everything
    endcase

    // full declared length known: control limit, then general limit
    if (len_chk) begin
      if (hdr0_r[3] && len_full > {57'd0, limits.max_control}) begin
        res_nxt   = 1'b1;
        ocode_nxt = wsdf_pkg::ERR_CTRL_LONG;
      end else if (len_full > {32'd0, limits.max_payload}) begin
        res_nxt   = 1'b1;
        ocode_nxt = wsdf_pkg::ERR_TOO_LONG;
      end else begin
        left_nxt   = len_full[31:0];
        key_nxt    = 32'd0;
        keycnt_nxt = 2'd0;
        kidx_nxt   = 2'd0;
        phase_nxt  = wsdf_pkg::PH_MASK;
      end
    end

    // any result raised from the header or length checks is an error
    if (res_nxt && (phase_r == wsdf_pkg::PH_HDR1 || phase_r == wsdf_pkg::PH_EXT)) begin
      okind_nxt = wsdf_pkg::KIND_ERROR;
      phase_nxt = wsdf_pkg::PH_ERROR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= wsdf_pkg::PH_HDR0;
      ovld_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r <= phase_nxt;
        ovld_r  <= res_nxt;
      end else if (out_tready) begin
        ovld_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      hdr0_r   <= hdr0_nxt;
      dlen_r   <= dlen_nxt;
      ext_r    <= ext_nxt;
      key_r    <= key_nxt;
      keycnt_r <= keycnt_nxt;
      left_r   <= left_nxt;
      kidx_r   <= kidx_nxt;
      if (res_nxt) begin
        okind_r <= okind_nxt;
        odata_r <= odata_nxt;
        oop_r   <= op;
        olast_r <= olast_nxt;
        ocode_r <= ocode_nxt;
      end
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {1'b0, ocode_r, oop_r, odata_r};

`ifndef NO_ASSERTIONS
  // errors are sticky until reset
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == wsdf_pkg::PH_ERROR |=> phase_r == wsdf_pkg::PH_ERROR)
    else $error("deframer left error phase without reset");

  // payload phase always has bytes left to deliver
  a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == wsdf_pkg::PH_DATA |-> left_r != 32'd0)
    else $error("payload phase with zero bytes left");

  // error results carry neither data nor last
  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r && okind_r == wsdf_pkg::KIND_ERROR |-> !olast_r && odata_r == 8'd0)
    else $error("error result with data or last set");

  // an error result puts the parser into the error phase
  a_err_phase: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && res_nxt && okind_nxt == wsdf_pkg::KIND_ERROR
      |=> phase_r == wsdf_pkg::PH_ERROR)
    else $error("error result without entering error phase");
`endif

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the WebSocket frame deframer. An initial block builds
// masked client frames byte by byte under several limit settings and idle
// patterns. A clocked driver feeds them into the core. A clocked monitor
// predicts each result as its byte is accepted and checks the core's results
// field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  // frame opcodes that pass the header check
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam int WATCHDOG_LIMIT = 3000;  // cycles without any handshake or APB select
  localparam int PHASE_BYTES    = 300;   // minimum random bytes per settings phase
  localparam int NUM_PHASES     = 5;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [3:0] opcode;
    logic       last;
    logic [2:0] error_code;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;   // [7:0] data_byte, [11:8] opcode, [14:12] error_code
  logic [1:0]  out_tuser;   // [1:0] kind
  logic        out_tlast;   // last
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  websocket_frame_deframer_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Stimulus and scoreboard storage
  // --------------------------------------------------------------------------
  logic [7:0]    rx_bytes_q[$];       // stream bytes not yet offered
  frame_result_t frame_results_q[$];  // predicted results, oldest first
  int            queued_bytes = 0;
  int            mismatches = 0;
  int            idle_cycles = 0;
  int            src_idle_pct = 0;    // chance per cycle that the sender idles
  int            sink_stall_pct = 0;  // chance per cycle that the receiver stalls
  logic          byte_taken = 1'b0;   // in_* handshake completed at the last edge

  // limits as the core should hold them
  logic [31:0]   lim_payload = wsdf_pkg::MAX_PAYLOAD_RST;
  logic [6:0]    lim_control = wsdf_pkg::MAX_CONTROL_RST;

  // --------------------------------------------------------------------------
  // Deframer prediction state
  // --------------------------------------------------------------------------
  logic [2:0]    parse_phase = wsdf_pkg::PH_HDR0;
  logic [7:0]    hdr_first = 8'h00;
  logic [63:0]   frame_len = 64'h0;
  logic [3:0]    ext_left = 4'h0;
  logic [31:0]   mask_word = 32'h0;
  logic [2:0]    key_cnt = 3'h0;
  logic [31:0]   bytes_left = 32'h0;
  logic [1:0]    key_pos = 2'h0;

  function automatic void raise_error(input logic [2:0] code, output frame_result_t r);
    parse_phase  = wsdf_pkg::PH_ERROR;
    r            = '0;
    r.kind       = wsdf_pkg::KIND_ERROR;
    r.opcode     = hdr_first[3:0];
    r.error_code = code;
  endfunction

  // full length known: control limit first, then the general one
  function automatic bit check_length(output frame_result_t r);
    r = '0;
    r.opcode = hdr_first[3:0];
    if (hdr_first[3] && frame_len > {57'h0, lim_control}) begin
      raise_error(wsdf_pkg::ERR_CTRL_LONG, r);
      return 1'b1;
    end
    if (frame_len > {32'h0, lim_payload}) begin
      raise_error(wsdf_pkg::ERR_TOO_LONG, r);
      return 1'b1;
    end
    bytes_left  = frame_len[31:0];
    mask_word   = 32'h0;
    key_cnt     = 3'h0;
    key_pos     = 2'h0;
    parse_phase = wsdf_pkg::PH_MASK;
    return 1'b0;
  endfunction

  // Advances the parser by one received byte; returns 1 when it yields a result.
  function automatic bit deframe_byte(input logic [7:0] b, output frame_result_t r);
    logic [3:0] op;
    logic [7:0] kb;
    bit         hit;
    hit = 1'b0;
    r = '0;
    r.opcode = hdr_first[3:0];
    op = hdr_first[3:0];
    case (parse_phase)
      wsdf_pkg::PH_HDR0: begin
        hdr_first   = b;
        parse_phase = wsdf_pkg::PH_HDR1;
      end
      wsdf_pkg::PH_HDR1: begin
        hit = 1'b1;
        if (hdr_first[6:4] != 3'b000) begin
          raise_error(wsdf_pkg::ERR_RSV, r);
        end else if (!hdr_first[7]) begin
          raise_error(wsdf_pkg::ERR_NOT_FINAL, r);
        end else if (!b[7]) begin
          raise_error(wsdf_pkg::ERR_UNMASKED, r);
        end else if (op > OP_PONG || (op > OP_BIN && op < OP_CLOSE)) begin
          raise_error(wsdf_pkg::ERR_BAD_OP, r);
        end else if (b[6:0] == wsdf_pkg::LEN7_EXT16) begin
          frame_len = 64'h0;
          ext_left = 4'd2;
          parse_phase = wsdf_pkg::PH_EXT;
          hit = 1'b0;
        end else if (b[6:0] == wsdf_pkg::LEN7_EXT64) begin
          frame_len = 64'h0;
          ext_left = 4'd8;
          parse_phase = wsdf_pkg::PH_EXT;
          hit = 1'b0;
        end else begin
          frame_len = {57'h0, b[6:0]};
          hit = check_length(r);
        end
      end
      wsdf_pkg::PH_EXT: begin
        frame_len = {frame_len[55:0], b};
        ext_left = ext_left - 4'd1;
        if (ext_left == 4'd0) hit = check_length(r);
      end
      wsdf_pkg::PH_MASK: begin
        mask_word = {mask_word[23:0], b};
        key_cnt = key_cnt + 3'd1;
        if (key_cnt >= 3'd4) begin
          key_pos = 2'h0;
          if (bytes_left == 32'h0) begin
            // empty payload completes as soon as the key is in
            parse_phase = wsdf_pkg::PH_HDR0;
            r.kind = wsdf_pkg::KIND_EMPTY;
            r.last = 1'b1;
            hit = 1'b1;
          end else begin
            parse_phase = wsdf_pkg::PH_DATA;
          end
        end
      end
      wsdf_pkg::PH_DATA: begin
        kb = mask_word[31 - 8 * key_pos -: 8];
        key_pos = key_pos + 2'd1;
        bytes_left = bytes_left - 32'd1;
        r.kind = wsdf_pkg::KIND_DATA;
        r.data_byte = b ^ kb;
        r.last = (bytes_left == 32'h0);
        if (r.last) parse_phase = wsdf_pkg::PH_HDR0;
        hit = 1'b1;
      end
      default: ;  // sticky error: bytes are swallowed
    endcase
    return hit;
  endfunction

  // --------------------------------------------------------------------------
  // Frame builders
  // --------------------------------------------------------------------------
  function automatic void push_byte(input logic [7:0] b);
    rx_bytes_q.push_back(b);
    queued_bytes++;
  endfunction

  // form: 0 shortest length encoding, 1 at least 16-bit, 2 always 64-bit
  function automatic void queue_header(input logic [7:0] hdr0, input logic [63:0] len,
                                       input int form);
    push_byte(hdr0);
    if (form == 0 && len < 64'd126) begin
      push_byte({1'b1, len[6:0]});          // mask bit set
    end else if (form <= 1 && len < 64'd65536) begin
      push_byte({1'b1, wsdf_pkg::LEN7_EXT16});
      push_byte(len[15:8]);
      push_byte(len[7:0]);
    end else begin
      push_byte({1'b1, wsdf_pkg::LEN7_EXT64});
      for (int i = 7; i >= 0; i--) push_byte(len[8 * i +: 8]);
    end
  endfunction

  function automatic void queue_frame(input logic [3:0] op, input logic [63:0] len,
                                      input int form);
    logic [31:0] key;
    key = $urandom;
    queue_header({1'b1, 3'b000, op}, len, form);
    for (int i = 3; i >= 0; i--) push_byte(key[8 * i +: 8]);
    for (longint unsigned i = 0; i < len; i++) push_byte(8'($urandom));
  endfunction

  // Well-formed frame within the current limits; mostly short payloads.
  function automatic void queue_random_frame();
    logic [3:0]      ops[6];
    logic [3:0]      op;
    longint unsigned cap;
    longint unsigned len;
    int              pick;
    int              form;
    ops = '{OP_CONT, OP_TEXT, OP_BIN, OP_CLOSE, OP_PING, OP_PONG};
    op = ops[$urandom_range(5)];
    cap = lim_payload;
    if (op[3] && lim_control < cap) cap = lim_control;
    pick = $urandom_range(99);
    if (pick < 70)      len = $urandom_range(8);
    else if (pick < 95) len = $urandom_range(40);
    else                len = $urandom_range(300);
    if (cap <= 300 && $urandom_range(15) == 0) len = cap;  // right at the limit
    if (len > cap) len = cap;
    form = ($urandom_range(9) < 7) ? 0 : $urandom_range(1, 2);
    queue_frame(op, len, form);
  endfunction

  // One header that breaks a rule, then noise. Errors stick until reset, so
  // this can only close the run; the seed picks which rule is broken.
  function automatic void queue_broken_frame();
    logic [2:0]  code;
    logic [3:0]  op;
    logic [63:0] len;
    code = 3'($urandom_range(5));
    case (code)
      wsdf_pkg::ERR_RSV: begin
        // FIN random too: reserved bits win over the other header checks
        push_byte({1'($urandom), 3'($urandom_range(1, 7)), 4'($urandom)});
        push_byte(8'($urandom));
      end
      wsdf_pkg::ERR_NOT_FINAL: begin
        push_byte({4'b0000, 4'($urandom)});
        push_byte(8'($urandom));
      end
      wsdf_pkg::ERR_UNMASKED: begin
        push_byte({4'b1000, 4'($urandom)});
        push_byte({1'b0, 7'($urandom)});
      end
      wsdf_pkg::ERR_BAD_OP: begin
        op = $urandom_range(1) ? 4'($urandom_range(3, 7)) : 4'($urandom_range(11, 15));
        push_byte({4'b1000, op});
        push_byte({1'b1, 7'($urandom)});
      end
      wsdf_pkg::ERR_CTRL_LONG: begin
        op = OP_CLOSE + 4'($urandom_range(2));
        len = 64'(lim_control) + 64'd1 + 64'($urandom_range(200));
        queue_header({4'b1000, op}, len, $urandom_range(2));
      end
      default: begin
        if (lim_payload != 32'hFFFF_FFFF && $urandom_range(1))
          len = 64'(lim_payload) + 64'd1;
        else
          len = {32'($urandom) | 32'h1, 32'($urandom)};
        queue_header({4'b1000, OP_BIN}, len, 2);
      end
    endcase
    repeat (24) push_byte(8'($urandom));
  endfunction

  // --------------------------------------------------------------------------
  // Driver: in_* and out_tready change on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || byte_taken) begin
        if (rx_bytes_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= rx_bytes_q.pop_front();
        end else begin
          in_tvalid <= 1'b0;
          in_tdata  <= 8'($urandom);
        end
      end
      out_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: sample both handshakes on the rising edge
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    frame_result_t want;
    frame_result_t pred;
    if (rst_n) begin
      // results are registered after their byte is accepted, so check before predicting
      if (out_tvalid && out_tready) begin
        if (frame_results_q.size() == 0) begin
          $error("unexpected result: kind %0d tdata 0x%0h", out_tuser, out_tdata);
          mismatches++;
        end else begin
          want = frame_results_q.pop_front();
          check_field("kind", 8'(want.kind), 8'(out_tuser));
          check_field("data_byte", want.data_byte, out_tdata[7:0]);
          check_field("opcode", 8'(want.opcode), 8'(out_tdata[11:8]));
          check_field("last", 8'(want.last), 8'(out_tlast));
          check_field("error_code", 8'(want.error_code), 8'(out_tdata[14:12]));
        end
      end
      if (in_tvalid && in_tready) begin
        if (deframe_byte(in_tdata, pred)) frame_results_q.push_back(pred);
      end
      byte_taken <= in_tvalid && in_tready;

      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencing
  // --------------------------------------------------------------------------
  // wait until every queued byte is in and every predicted result is out
  task automatic wait_stream_idle(input int tail);
    while (rx_bytes_q.size() != 0 || in_tvalid || frame_results_q.size() != 0)
      @(posedge clk);
    repeat (tail) @(negedge clk);
  endtask

  // APB write, then read back the same register
  task automatic write_limit(input logic sel, input logic [31:0] value);
    logic [31:0] rd;
    logic [31:0] held;
    held = (sel == wsdf_pkg::REG_MAX_CONTROL) ? {25'h0, value[6:0]} : value;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);               // written at the edge just passed
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (sel == wsdf_pkg::REG_MAX_CONTROL) lim_control = value[6:0];
    else                                  lim_payload = value;
    if (rd !== held) begin
      $error("prdata: expected 0x%0h, got 0x%0h", held, rd);
      mismatches++;
    end
  endtask

  initial begin
    logic [31:0] payload_lims[NUM_PHASES];
    logic [6:0]  control_lims[NUM_PHASES];
    int          src_pct[4];
    int          sink_pct[4];
    int          start;

    // extremes of both limits, a tight payload limit, and the reset defaults
    payload_lims = '{32'hFFFF_FFFF, 32'd0, 32'd37, wsdf_pkg::MAX_PAYLOAD_RST, 32'd1};
    control_lims = '{7'd127, 7'd0, wsdf_pkg::MAX_CONTROL_RST, 7'd5, 7'd127};
    src_pct  = '{0, 69, 0, 6};
    sink_pct = '{0, 0, 69, 6};

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = 3'h0;
    cfg_pwdata  = 32'h0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty control frame, 16-bit length form, short ping, defaults
    queue_frame(OP_CLOSE, 64'd0, 0);
    queue_frame(OP_TEXT, 64'd3, 1);
    queue_frame(OP_PING, 64'd1, 0);
    wait_stream_idle(4);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_limit(wsdf_pkg::REG_MAX_PAYLOAD, payload_lims[p]);
      write_limit(wsdf_pkg::REG_MAX_CONTROL, 32'(control_lims[p]));
      src_idle_pct   = src_pct[p % 4];
      sink_stall_pct = sink_pct[p % 4];
      start = queued_bytes;
      while (queued_bytes - start < PHASE_BYTES) queue_random_frame();
      wait_stream_idle(4);
    end

    // sticky error closes the run, with some backpressure on both sides
    src_idle_pct   = 6;
    sink_stall_pct = 6;
    queue_broken_frame();
    wait_stream_idle(8);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
